// ===== rtl/gmi_pkg.sv =====
package gmi_pkg;

   localparam int DATA_W      = 32;
   localparam int PTS_W       = 5;
   localparam int ADDR_W      = 8;
   localparam int TABLE_DEPTH = 256;
   localparam int WGT_W       = 17;
   localparam int OPA_W       = 34;
   localparam int OPB_W       = 33;
   localparam int PROD_W      = 66;
   localparam int CSR_AW      = 5;

   localparam int DEFAULT_DIMS       = 2;
   localparam int DEFAULT_MAX_POINTS = 16;

   localparam logic [WGT_W-1:0]  FRAC_ONE      = 17'h10000;
   localparam logic [DATA_W-1:0] INV_RESET     = 32'h0001_0000;
   localparam logic [PTS_W-1:0]  POINTS_RESET  = 5'd16;

   typedef enum logic {
      REQ_WRITE = 1'b0,
      REQ_EVAL  = 1'b1
   } req_kind_type;

   typedef enum logic [2:0] {
      REG_ORIGIN_X = 3'd0,
      REG_ORIGIN_Y = 3'd1,
      REG_INV_X    = 3'd2,
      REG_INV_Y    = 3'd3,
      REG_POINTS_X = 3'd4,
      REG_POINTS_Y = 3'd5
   } reg_index_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] origin_x;
      logic signed [DATA_W-1:0] origin_y;
      logic [DATA_W-1:0]        inv_x;
      logic [DATA_W-1:0]        inv_y;
      logic [PTS_W-1:0]         points_x;
      logic [PTS_W-1:0]         points_y;
   } cfg_type;

   typedef struct packed {
      logic [PTS_W-1:0] lo;
      logic [PTS_W-1:0] hi;
      logic [WGT_W-1:0] frac;
   } loc_type;

   // grid cell and fraction from the q32.32 product of offset and inverse spacing
   function automatic loc_type locate(input logic [63:0] prod, input logic neg,
                                      input logic [PTS_W-1:0] pts);
      loc_type          r;
      logic [PTS_W-1:0] last;
      logic [31:0]      last_ext;
      last     = pts - 1'b1;
      last_ext = {{(32-PTS_W){1'b0}}, last};
      if (neg && (prod != '0)) begin
         r.lo   = '0;
         r.hi   = '0;
         r.frac = '0;
      end else if (prod[63:32] >= last_ext) begin
         r.lo   = last;
         r.hi   = last;
         r.frac = (prod[63:32] > last_ext) ? FRAC_ONE : {1'b0, prod[31:16]};
      end else begin
         r.lo   = prod[32 +: PTS_W];
         r.hi   = prod[32 +: PTS_W] + 1'b1;
         r.frac = {1'b0, prod[31:16]};
      end
      return r;
   endfunction

endpackage

// ===== rtl/grid_multilinear_interpolator.sv =====
// evaluate word: busy while the sequencer steps from S_DIFF through S_FIN, then the result is
// registered and strobed on rsp_valid; no new word is accepted until busy falls
// write word: busy stays low, a write may follow in every cycle while no evaluate is busy
// evaluate throughput is set by the single shared multiplier (10 products per evaluate)
// and the one-read-per-cycle table ram
// synchronous reset restores register defaults and marks every table entry zero at once
module grid_multilinear_interpolator
   import gmi_pkg::*;
   #(parameter int DIMS       = DEFAULT_DIMS,
     parameter int MAX_POINTS = DEFAULT_MAX_POINTS)
   (input  logic                     clock,
    input  logic                     reset,
    input  logic                     start,
    output logic                     busy,
    input  logic                     req_type,
    input  logic [ADDR_W-1:0]        req_entry_index,
    input  logic signed [DATA_W-1:0] req_entry_value,
    input  logic signed [DATA_W-1:0] req_coord_x,
    input  logic signed [DATA_W-1:0] req_coord_y,
    output logic                     rsp_valid,
    output logic signed [DATA_W-1:0] rsp_interp_value,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [CSR_AW-1:0]        paddr,
    input  logic [DATA_W-1:0]        pwdata,
    output logic [DATA_W-1:0]        prdata,
    output logic                     pready);

   typedef enum logic [3:0] {
      S_IDLE, S_DIFF, S_MX, S_MY, S_RY,
      S_W0, S_V0, S_W1, S_V1, S_W2, S_V2, S_W3, S_V3, S_FIN
   } state_type;

   cfg_type cfg;

   gmi_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg));

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic signed [DATA_W-1:0] rsp_value_ff, rsp_value_in;

   logic [DATA_W-1:0] coord_x_ff, coord_x_in, coord_y_ff, coord_y_in;
   logic [DATA_W-1:0] mag_x_ff, mag_x_in, mag_y_ff, mag_y_in;
   logic              neg_x_ff, neg_x_in, neg_y_ff, neg_y_in;
   logic [PTS_W-1:0]  xlo_ff, xlo_in, xhi_ff, xhi_in;
   logic [WGT_W-1:0]  fx_ff, fx_in, fy_ff, fy_in;
   logic [ADDR_W-1:0] row0_ff, row0_in, row1_ff, row1_in;
   logic signed [PROD_W-1:0] acc_ff, acc_in;
   logic              rd_vld_ff;
   logic [TABLE_DEPTH-1:0] valid_ff;

   logic accept, wr_en;
   logic [ADDR_W-1:0] rd_addr;
   logic [DATA_W-1:0] rd_data, rd_eff;
   logic signed [OPA_W-1:0]  mul_a;
   logic signed [OPB_W-1:0]  mul_b;
   logic signed [PROD_W-1:0] prod;
   logic [PTS_W-1:0] px, py;
   logic [DATA_W:0]  dx, dy, ax, ay;
   loc_type          loc;
   logic [2*PTS_W-1:0] row0_full, row1_full;
   logic cx, cy, weight_step, value_step;
   logic [WGT_W-1:0] wx, wy;
   logic [PTS_W-1:0] xsel;
   logic [ADDR_W-1:0] rowsel;
   logic signed [PROD_W-1:0] sum;

   assign busy   = (state_ff != S_IDLE);
   assign accept = start && !busy;
   assign wr_en  = accept && (req_type == REQ_WRITE);

   gmi_ram #(.WIDTH(DATA_W), .DEPTH(TABLE_DEPTH)) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (req_entry_index),
      .wr_data (req_entry_value),
      .rd_addr (rd_addr),
      .rd_data (rd_data));

   gmi_mul u_mul (
      .clock (clock),
      .op_a  (mul_a),
      .op_b  (mul_b),
      .prod  (prod));

   // never-written entries read as zero
   assign rd_eff = rd_vld_ff ? rd_data : '0;

   // clamp point counts to two up to the grid maximum
   always_comb begin
      if (cfg.points_x < 2) begin
         px = PTS_W'(2);
      end else if (int'(cfg.points_x) > MAX_POINTS) begin
         px = PTS_W'(MAX_POINTS);
      end else begin
         px = cfg.points_x;
      end
      if (cfg.points_y < 2) begin
         py = PTS_W'(2);
      end else if (int'(cfg.points_y) > MAX_POINTS) begin
         py = PTS_W'(MAX_POINTS);
      end else begin
         py = cfg.points_y;
      end
   end

   assign dx = {coord_x_ff[DATA_W-1], coord_x_ff} - {cfg.origin_x[DATA_W-1], cfg.origin_x};
   assign dy = {coord_y_ff[DATA_W-1], coord_y_ff} - {cfg.origin_y[DATA_W-1], cfg.origin_y};
   assign ax = dx[DATA_W] ? (~dx + 1'b1) : dx;
   assign ay = dy[DATA_W] ? (~dy + 1'b1) : dy;

   // corner order: x low/high inner, y low/high outer
   assign weight_step = (state_ff == S_W0) || (state_ff == S_W1) ||
                        (state_ff == S_W2) || (state_ff == S_W3);
   assign value_step  = (state_ff == S_V0) || (state_ff == S_V1) ||
                        (state_ff == S_V2) || (state_ff == S_V3);
   assign cx     = (state_ff == S_W1) || (state_ff == S_W3);
   assign cy     = (state_ff == S_W2) || (state_ff == S_W3);
   assign wx     = cx ? fx_ff : (FRAC_ONE - fx_ff);
   assign wy     = cy ? fy_ff : (FRAC_ONE - fy_ff);
   assign xsel   = cx ? xhi_ff : xlo_ff;
   assign rowsel = cy ? row1_ff : row0_ff;
   assign rd_addr = {{(ADDR_W-PTS_W){1'b0}}, xsel} + rowsel;
   assign sum    = acc_ff + prod;

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         S_MX: begin
            mul_a = {2'b00, mag_x_ff};
            mul_b = {1'b0, cfg.inv_x};
         end
         S_MY: begin
            mul_a = {2'b00, mag_y_ff};
            mul_b = {1'b0, cfg.inv_y};
         end
         S_W0, S_W1, S_W2, S_W3: begin
            mul_a = {{(OPA_W-WGT_W){1'b0}}, wx};
            mul_b = {{(OPB_W-WGT_W){1'b0}}, wy};
         end
         S_V0, S_V1, S_V2, S_V3: begin
            // corner weight is at most 2^32, held in the low 33 bits
            mul_a = {1'b0, prod[OPB_W-1:0]};
            mul_b = {rd_eff[DATA_W-1], rd_eff};
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = 1'b0;
      rsp_value_in = rsp_value_ff;
      coord_x_in   = coord_x_ff;
      coord_y_in   = coord_y_ff;
      mag_x_in     = mag_x_ff;
      mag_y_in     = mag_y_ff;
      neg_x_in     = neg_x_ff;
      neg_y_in     = neg_y_ff;
      xlo_in       = xlo_ff;
      xhi_in       = xhi_ff;
      fx_in        = fx_ff;
      fy_in        = fy_ff;
      row0_in      = row0_ff;
      row1_in      = row1_ff;
      acc_in       = acc_ff;
      loc          = '0;
      row0_full    = '0;
      row1_full    = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (accept && (req_type == REQ_EVAL)) begin
               coord_x_in = req_coord_x;
               coord_y_in = req_coord_y;
               state_in   = S_DIFF;
            end
         end
         S_DIFF: begin
            mag_x_in = ax[DATA_W-1:0];
            neg_x_in = dx[DATA_W];
            mag_y_in = ay[DATA_W-1:0];
            neg_y_in = dy[DATA_W];
            state_in = S_MX;
         end
         S_MX: state_in = S_MY;
         S_MY: begin
            loc      = locate(prod[63:0], neg_x_ff, px);
            xlo_in   = loc.lo;
            xhi_in   = loc.hi;
            fx_in    = loc.frac;
            state_in = S_RY;
         end
         S_RY: begin
            if (DIMS >= 2) begin
               loc = locate(prod[63:0], neg_y_ff, py);
            end else begin
               loc = '0;
            end
            row0_full = loc.lo * px;
            row1_full = loc.hi * px;
            row0_in   = row0_full[ADDR_W-1:0];
            row1_in   = row1_full[ADDR_W-1:0];
            fy_in     = loc.frac;
            state_in  = S_W0;
         end
         S_W0: begin
            acc_in   = '0;
            state_in = S_V0;
         end
         S_V0: state_in = S_W1;
         S_W1: begin
            acc_in   = sum;
            state_in = S_V1;
         end
         S_V1: state_in = S_W2;
         S_W2: begin
            acc_in   = sum;
            state_in = S_V2;
         end
         S_V2: state_in = S_W3;
         S_W3: begin
            acc_in   = sum;
            state_in = S_V3;
         end
         S_V3: state_in = S_FIN;
         S_FIN: begin
            rsp_value_in = sum[63:32];
            rsp_valid_in = 1'b1;
            state_in     = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_value_ff <= rsp_value_in;
   end

   always_ff @(posedge clock) begin
      coord_x_ff <= coord_x_in;
      coord_y_ff <= coord_y_in;
      mag_x_ff   <= mag_x_in;
      mag_y_ff   <= mag_y_in;
      neg_x_ff   <= neg_x_in;
      neg_y_ff   <= neg_y_in;
      xlo_ff     <= xlo_in;
      xhi_ff     <= xhi_in;
      fx_ff      <= fx_in;
      fy_ff      <= fy_in;
      row0_ff    <= row0_in;
      row1_ff    <= row1_in;
      acc_ff     <= acc_in;
      rd_vld_ff  <= valid_ff[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr_en) begin
         valid_ff[req_entry_index] <= 1'b1;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_interp_value = rsp_value_ff;

   a_rsp_after_fin: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(state_ff == S_FIN))
      else $error("result strobe without a finished evaluate");

   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result strobe while still busy");

   a_eval_starts: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_type == REQ_EVAL)) |=> (state_ff == S_DIFF))
      else $error("evaluate word accepted but sequencer did not start");

   a_write_no_busy: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_type == REQ_WRITE)) |=> !busy && !rsp_valid)
      else $error("write word started a sequence or produced a result");

   a_corner_pairs: assert property (@(posedge clock) disable iff (reset)
      value_step |-> $past(weight_step))
      else $error("value product without a preceding weight product");

endmodule

// ===== rtl/gmi_ram.sv =====
module gmi_ram
   #(parameter int WIDTH = 32,
     parameter int DEPTH = 256)
   (input  logic                     clock,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/gmi_mul.sv =====
module gmi_mul
   import gmi_pkg::*;
   (input  logic                     clock,
    input  logic signed [OPA_W-1:0]  op_a,
    input  logic signed [OPB_W-1:0]  op_b,
    output logic signed [PROD_W-1:0] prod);

   logic signed [OPA_W+OPB_W-1:0] full;
   logic signed [PROD_W-1:0]      prod_ff;
   logic signed [PROD_W-1:0]      prod_in;

   // every product used here fits in the low bits
   assign full    = op_a * op_b;
   assign prod_in = full[PROD_W-1:0];

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign prod = prod_ff;

endmodule

// ===== rtl/gmi_csr.sv =====
module gmi_csr
   import gmi_pkg::*;
   (input  logic              clock,
    input  logic              reset,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [CSR_AW-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output cfg_type           cfg);

   cfg_type       cfg_ff;
   cfg_type       cfg_in;
   reg_index_type idx;
   logic          wr_en;

   assign idx    = reg_index_type'(paddr[CSR_AW-1:2]);
   assign wr_en  = psel && penable && pwrite;
   assign pready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (idx)
            REG_ORIGIN_X: cfg_in.origin_x = pwdata;
            REG_ORIGIN_Y: cfg_in.origin_y = pwdata;
            REG_INV_X:    cfg_in.inv_x    = pwdata;
            REG_INV_Y:    cfg_in.inv_y    = pwdata;
            REG_POINTS_X: cfg_in.points_x = pwdata[PTS_W-1:0];
            REG_POINTS_Y: cfg_in.points_y = pwdata[PTS_W-1:0];
            default:      cfg_in          = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (idx)
         REG_ORIGIN_X: prdata = cfg_ff.origin_x;
         REG_ORIGIN_Y: prdata = cfg_ff.origin_y;
         REG_INV_X:    prdata = cfg_ff.inv_x;
         REG_INV_Y:    prdata = cfg_ff.inv_y;
         REG_POINTS_X: prdata = {{(DATA_W-PTS_W){1'b0}}, cfg_ff.points_x};
         REG_POINTS_Y: prdata = {{(DATA_W-PTS_W){1'b0}}, cfg_ff.points_y};
         default:      prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.origin_x <= '0;
         cfg_ff.origin_y <= '0;
         cfg_ff.inv_x    <= INV_RESET;
         cfg_ff.inv_y    <= INV_RESET;
         cfg_ff.points_x <= POINTS_RESET;
         cfg_ff.points_y <= POINTS_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule
